### hw/rtl/indexed_max_heap_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the indexed max-heap
// Concurrent assertion wrappers; they expand to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef INDEXED_MAX_HEAP_DEFINES_SVH
`define INDEXED_MAX_HEAP_DEFINES_SVH
`ifndef SYNTH
`define IMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IMH_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define IMH_ASSERT(lbl, prop, msg)
`define IMH_NEVER(lbl, cond, msg)
`endif
`endif

### hw/rtl/imh_pkg.sv
// ---------------------------------------------------------------------------
// imh_pkg
// Types and codes shared by the indexed max-heap modules.
// ---------------------------------------------------------------------------
`default_nettype none
package imh_pkg;
  localparam int KeyW  = 10;
  localparam int PrioW = 32;
  localparam int ModeW = 3;
  localparam int StatW = 3;
  localparam int CntW  = 11;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_UPDATE = 3'd2,
    MODE_QUERY  = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [PrioW-1:0] prio;
  } heap_ent_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_LOOK, S_LOOK2, S_POP,
    S_SUR, S_SUC, S_SDR, S_SDC, S_FIN, S_DONE
  } state_t;
endpackage
`default_nettype wire

### hw/rtl/imh_if.sv
// ---------------------------------------------------------------------------
// imh_in_if / imh_out_if
// Valid/ready channels for operation beats and result beats.
// ---------------------------------------------------------------------------
`default_nettype none
interface imh_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [9:0]  key;
  logic [31:0] value;
  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

interface imh_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  out_key;
  logic [31:0] out_value;
  logic        present;
  logic [2:0]  status;
  logic [10:0] count;
  modport source (output valid, out_key, out_value, present, status, count, input ready);
  modport sink   (input valid, out_key, out_value, present, status, count, output ready);
endinterface
`default_nettype wire

### hw/rtl/imh_heap_mem.sv
// ---------------------------------------------------------------------------
// imh_heap_mem
// Heap slot store: key and priority per slot, two registered reads, one write.
// ---------------------------------------------------------------------------
`default_nettype none
module imh_heap_mem
  import imh_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire heap_ent_t       wdata,
  input  wire logic [AW-1:0]   raddr_a,
  input  wire logic [AW-1:0]   raddr_b,
  output heap_ent_t            rdata_a,
  output heap_ent_t            rdata_b
);
  heap_ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

### hw/rtl/imh_pos_mem.sv
// ---------------------------------------------------------------------------
// imh_pos_mem
// Slot-of-key store: one registered read, one write.
// ---------------------------------------------------------------------------
`default_nettype none
module imh_pos_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [DW-1:0]      rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/indexed_max_heap.sv
// ---------------------------------------------------------------------------
// indexed_max_heap
// Indexed binary max-heap priority queue with a key-to-slot table.
// ---------------------------------------------------------------------------
// After reset the block sweeps the slot-of-key table, one entry a cycle, over
// all min(NUM_KEYS,1024) entries before it takes its first beat. One
// operation is in flight at a time. Clear, the unused modes and a pop on an
// empty heap go from the accepting state straight to the result; query, the
// push and update error cases and an update to an equal value first read the
// key's table slot and then its heap slot. Push and update climb or descend
// one heap level per step (one memory read, one compare and write back); pop
// reads the root and last slot together and then descends the same way. A
// result held by a stalled receiver delays the next one. A key is present
// when its table slot lies below the entry count and that slot holds the
// key, so clear needs no sweep.
`default_nettype none
module indexed_max_heap
  import imh_pkg::*;
#(
  parameter int NUM_KEYS = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  imh_in_if.sink     in_ch,
  imh_out_if.source  out_ch
);
  `include "indexed_max_heap_defines.svh"

  localparam int AW  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CW  = $clog2(NUM_KEYS + 1);
  localparam int KD  = (NUM_KEYS < 1024) ? NUM_KEYS : 1024;
  localparam int KAW = $clog2(KD);
  localparam int XW  = CW + CntW;
  localparam logic [31:0] NkW = 32'(NUM_KEYS);
  localparam logic [CW-1:0] NkC = CW'(NUM_KEYS);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [KAW-1:0]  init_r, init_nxt;
  logic [ModeW-1:0] mode_r, mode_nxt;
  logic [KeyW-1:0] key_r, key_nxt;
  logic [PrioW-1:0] val_r, val_nxt;
  logic [CW-1:0]   slot_r, slot_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  heap_ent_t       mov_r, mov_nxt;
  logic [KeyW-1:0] rkey_r, rkey_nxt;
  logic [PrioW-1:0] rval_r, rval_nxt;
  logic            rpres_r, rpres_nxt;
  status_t         rstat_r, rstat_nxt;
  logic            ovalid_r, ovalid_nxt;
  logic [KeyW-1:0] okey_r, okey_nxt;
  logic [PrioW-1:0] oval_r, oval_nxt;
  logic            opres_r, opres_nxt;
  status_t         ostat_r, ostat_nxt;
  logic [CntW-1:0] ocnt_r, ocnt_nxt;

  logic            h_we;
  logic [AW-1:0]   h_waddr, h_ra, h_rb;
  heap_ent_t       h_wdata, h_qa, h_qb;
  logic            p_we;
  logic [KAW-1:0]  p_waddr, p_raddr;
  logic [CW-1:0]   p_wdata, p_q;

  logic            in_range, here, acc;
  logic [CW:0]     lchild, rchild;
  logic [CW-1:0]   parent;
  heap_ent_t       best;
  logic            best_child;
  logic [CW-1:0]   best_idx;
  logic [XW-1:0]   cnt_w;

  imh_heap_mem #(.DEPTH(NUM_KEYS), .AW(AW)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr_a(h_ra), .raddr_b(h_rb), .rdata_a(h_qa), .rdata_b(h_qb)
  );

  imh_pos_mem #(.DEPTH(KD), .AW(KAW), .DW(CW)) u_pos (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_q)
  );

  assign in_ch.ready      = (state_r == S_IDLE);
  assign acc              = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = ovalid_r;
  assign out_ch.out_key   = okey_r;
  assign out_ch.out_value = oval_r;
  assign out_ch.present   = opres_r;
  assign out_ch.status    = ostat_r;
  assign out_ch.count     = ocnt_r;

  assign in_range = (32'(key_r) < NkW);
  assign here     = in_range && (slot_r < count_r) && (h_qa.key == key_r);
  assign lchild   = {pos_r, 1'b1};
  assign rchild   = lchild + 1'b1;
  assign parent   = (pos_r - 1'b1) >> 1;
  assign cnt_w    = XW'(count_r);

  always_comb begin
    best       = mov_r;
    best_child = 1'b0;
    best_idx   = pos_r;
    if ((lchild < {1'b0, count_r}) && (h_qa.prio > best.prio)) begin
      best       = h_qa;
      best_child = 1'b1;
      best_idx   = lchild[CW-1:0];
    end
    if ((rchild < {1'b0, count_r}) && (h_qb.prio > best.prio)) begin
      best       = h_qb;
      best_child = 1'b1;
      best_idx   = rchild[CW-1:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    init_nxt   = init_r;
    mode_nxt   = mode_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    slot_nxt   = slot_r;
    pos_nxt    = pos_r;
    mov_nxt    = mov_r;
    rkey_nxt   = rkey_r;
    rval_nxt   = rval_r;
    rpres_nxt  = rpres_r;
    rstat_nxt  = rstat_r;
    okey_nxt   = okey_r;
    oval_nxt   = oval_r;
    opres_nxt  = opres_r;
    ostat_nxt  = ostat_r;
    ocnt_nxt   = ocnt_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    h_we       = 1'b0;
    h_waddr    = pos_r[AW-1:0];
    h_wdata    = mov_r;
    h_ra       = '0;
    h_rb       = AW'(count_r - 1'b1);
    p_we       = 1'b0;
    p_waddr    = mov_r.key[KAW-1:0];
    p_wdata    = pos_r;
    p_raddr    = in_ch.key[KAW-1:0];

    case (state_r)
      S_INIT: begin
        // Every key starts out pointing beyond any live slot.
        p_we     = 1'b1;
        p_waddr  = init_r;
        p_wdata  = '1;
        init_nxt = init_r + 1'b1;
        if (init_r == KAW'(KD - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          mode_nxt  = in_ch.mode;
          key_nxt   = in_ch.key;
          val_nxt   = in_ch.value;
          rkey_nxt  = in_ch.key;
          rval_nxt  = '0;
          rpres_nxt = 1'b0;
          rstat_nxt = ST_OK;
          case (in_ch.mode)
            MODE_PUSH, MODE_UPDATE, MODE_QUERY: state_nxt = S_LOOK;
            MODE_POP: begin
              if (count_r == '0) begin
                rstat_nxt = ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_POP;
              end
            end
            MODE_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_LOOK: begin
        slot_nxt  = p_q;
        h_ra      = p_q[AW-1:0];
        state_nxt = S_LOOK2;
      end
      S_LOOK2: begin
        state_nxt = S_DONE;
        mov_nxt   = '{key: key_r, prio: val_r};
        case (mode_r)
          MODE_PUSH: begin
            if (!in_range) begin
              rstat_nxt = ST_ABSENT;
            end else if (here) begin
              rstat_nxt = ST_PRESENT;
            end else if (count_r >= NkC) begin
              rstat_nxt = ST_FULL;
            end else begin
              pos_nxt   = count_r;
              count_nxt = count_r + 1'b1;
              state_nxt = S_SUR;
            end
          end
          MODE_UPDATE: begin
            if (!here) begin
              rstat_nxt = ST_ABSENT;
            end else begin
              pos_nxt = slot_r;
              if (val_r > h_qa.prio) begin
                state_nxt = S_SUR;
              end else if (val_r < h_qa.prio) begin
                state_nxt = S_SDR;
              end
            end
          end
          default: begin
            rpres_nxt = here;
            rval_nxt  = here ? h_qa.prio : '0;
          end
        endcase
      end
      S_POP: begin
        rkey_nxt  = h_qa.key;
        rval_nxt  = h_qa.prio;
        count_nxt = count_r - 1'b1;
        mov_nxt   = h_qb;
        pos_nxt   = '0;
        state_nxt = (count_r == CW'(1)) ? S_DONE : S_SDR;
      end
      S_SUR: begin
        h_ra      = parent[AW-1:0];
        state_nxt = (pos_r == '0) ? S_FIN : S_SUC;
      end
      S_SUC: begin
        if (h_qa.prio < mov_r.prio) begin
          // Parent moves down into the hole; the hole climbs one level.
          h_we      = 1'b1;
          h_wdata   = h_qa;
          p_we      = 1'b1;
          p_waddr   = h_qa.key[KAW-1:0];
          pos_nxt   = parent;
          state_nxt = S_SUR;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SDR: begin
        h_ra      = lchild[AW-1:0];
        h_rb      = rchild[AW-1:0];
        state_nxt = (lchild < {1'b0, count_r}) ? S_SDC : S_FIN;
      end
      S_SDC: begin
        if (best_child) begin
          h_we      = 1'b1;
          h_wdata   = best;
          p_we      = 1'b1;
          p_waddr   = best.key[KAW-1:0];
          pos_nxt   = best_idx;
          state_nxt = S_SDR;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        h_we      = 1'b1;
        p_we      = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          okey_nxt   = rkey_r;
          oval_nxt   = rval_r;
          opres_nxt  = rpres_r;
          ostat_nxt  = rstat_r;
          ocnt_nxt   = cnt_w[CntW-1:0];
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      count_r  <= '0;
      init_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      init_r   <= init_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    slot_r  <= slot_nxt;
    pos_r   <= pos_nxt;
    mov_r   <= mov_nxt;
    rkey_r  <= rkey_nxt;
    rval_r  <= rval_nxt;
    rpres_r <= rpres_nxt;
    rstat_r <= rstat_nxt;
    okey_r  <= okey_nxt;
    oval_r  <= oval_nxt;
    opres_r <= opres_nxt;
    ostat_r <= ostat_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  `IMH_ASSERT(a_count_bound, count_r <= NkC, "entry count beyond capacity")
  `IMH_NEVER(a_no_write_idle, (state_r == S_IDLE) && h_we, "heap written while idle")
  `IMH_ASSERT(a_hole_live, ((state_r == S_SUR) || (state_r == S_SDR)) |-> (pos_r < count_r),
              "sift position outside live heap")
endmodule
`default_nettype wire
